>>> rtl/core/rft_pkg.sv
package rft_pkg;

    // Scanner modes, one-hot.
    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_IDENT  = 4'b0010,
        MODE_STR    = 4'b0100,
        MODE_STR_AT = 4'b1000
    } t_mode;

    typedef enum logic [2:0] {
        KIND_IDENT  = 3'd0,
        KIND_STRING = 3'd1,
        KIND_SCOLON = 3'd2,
        KIND_COLON  = 3'd3,
        KIND_END    = 3'd4,
        KIND_ERROR  = 3'd5
    } t_kind;

    typedef struct packed {
        logic sym_ch;
        logic id_ch;
        logic sym;
        logic id;
        logic num;
    } t_flags;

    localparam t_flags FL_RESET = '{sym_ch: 1'b0, id_ch: 1'b0, sym: 1'b1, id: 1'b1, num: 1'b1};
    localparam t_flags FL_NONE  = '{default: 1'b0};

    localparam int unsigned LEN_BITS    = 32;
    localparam int unsigned RES_MAX     = 3;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned TDATA_W     = 72;

    typedef struct packed {
        t_kind                kind;
        logic [31:0]          start;
        logic [LEN_BITS-1:0]  len;
        logic                 num_valid;
        logic                 id_valid;
        logic                 sym_valid;
    } t_result;

    // All results caused by one input beat, in emission order.
    typedef struct packed {
        t_result [RES_MAX-1:0] res;
        logic [1:0]            cnt;
    } t_bundle;

    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_SCOLON = 8'h3B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

endpackage

>>> rtl/core/rcs_file_tokenizer_unit.sv
// RCS file tokenizer.
// The slave channel takes the file one byte per beat: tdata carries the byte and
// tlast marks the final byte of the file. The master channel delivers tokens, one
// per beat: tuser holds the token kind, tlast marks the last token caused by one
// input byte, and tdata holds start offset, length and the identifier flags.
// A front stage keeps the scan state and turns each byte into a bundle of zero to
// three tokens in the same cycle; a four-entry bundle queue decouples it from a
// back stage that hands tokens out one per cycle, while the receiver is ready,
// through an output register. Throughput is one byte per cycle as long as bytes
// average at most one token each; the output register's single token per cycle
// sets the rate otherwise. A token passes the bundle queue and then the output
// register before it is valid on the master side.
// When the receiver stalls, the output register holds its token, the queue fills
// and then the slave side drops tready; nothing is lost.
// Reset clears the scan state, the queue and the output valid. After the final
// byte of a file the scanner rearms by itself, so the next byte is offset zero.
module rcs_file_tokenizer_unit #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] data_byte
    input  logic                        i_s_tlast,   // end_of_file
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [31:0] start_offset, [63:32] token_length, [64] num_valid, [65] id_valid,
    // [66] sym_valid, [71:67] zero
    output logic [rft_pkg::TDATA_W-1:0] o_m_tdata,
    output logic [2:0]                  o_m_tuser,   // [2:0] kind
    output logic                        o_m_tlast    // last_of_run
);

    logic             push;
    logic             full;
    logic             empty;
    logic             pop;
    rft_pkg::t_bundle bundle;
    rft_pkg::t_bundle head;
    rft_pkg::t_result result;

    rft_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_s_tvalid),
        .i_byte       (i_s_tdata),
        .i_eof        (i_s_tlast),
        .o_byte_ready (o_s_tready),
        .i_queue_full (full),
        .o_push       (push),
        .o_bundle     (bundle)
    );

    rft_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .o_full   (full),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_head   (head)
    );

    rft_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (result),
        .o_last   (o_m_tlast)
    );

    // Token fields packed from the lowest bit up.
    assign o_m_tdata = {5'd0, result.sym_valid, result.id_valid, result.num_valid,
                        result.len, result.start};
    assign o_m_tuser = result.kind;

endmodule

>>> rtl/core/rft_front.sv
module rft_front #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_byte_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_eof,
    output logic            o_byte_ready,
    input  logic            i_queue_full,
    output logic            o_push,
    output rft_pkg::t_bundle o_bundle
);

    function automatic rft_pkg::t_flags classify(input rft_pkg::t_flags f_in,
                                                 input logic [7:0] c);
        rft_pkg::t_flags f;
        logic dig;
        logic pr;
        logic spec;
        f    = f_in;
        dig  = (c >= rft_pkg::CH_ZERO) && (c <= rft_pkg::CH_NINE);
        pr   = (c >= rft_pkg::CH_SPACE) && (c <= rft_pkg::CH_TILDE);
        spec = (c == rft_pkg::CH_DOLLAR) || (c == rft_pkg::CH_COMMA) ||
               (c == rft_pkg::CH_COLON) || (c == rft_pkg::CH_SCOLON) ||
               (c == rft_pkg::CH_AT);
        if (!dig && c != rft_pkg::CH_DOT) begin
            f.num   = 1'b0;
            f.id_ch = 1'b1;
        end
        if (spec || !pr) f.id = 1'b0;
        if (spec || c == rft_pkg::CH_DOT || !pr) f.sym = 1'b0;
        if (!dig) f.sym_ch = 1'b1;
        return f;
    endfunction

    function automatic rft_pkg::t_result mk_res(input rft_pkg::t_kind k,
                                                input logic [31:0] s,
                                                input logic [31:0] l,
                                                input rft_pkg::t_flags f);
        rft_pkg::t_result r;
        r.kind      = k;
        r.start     = s;
        r.len       = l;
        r.num_valid = f.num;
        r.id_valid  = f.id & f.id_ch;
        r.sym_valid = f.sym & f.sym_ch;
        return r;
    endfunction

    rft_pkg::t_mode             r_mode,  n_mode;
    logic [OFFSET_BITS-1:0]     r_pos,   n_pos;
    logic [OFFSET_BITS-1:0]     r_start, n_start;
    logic [31:0]                r_len,   n_len;
    rft_pkg::t_flags            r_flags, n_flags;

    rft_pkg::t_result [3:0]     cand;
    logic [3:0]                 cand_v;
    logic [2:0]                 fill;
    logic                       accept;
    logic                       blank;
    logic                       is_at;
    logic                       is_punct;
    logic                       delim;
    logic                       do_idle;
    logic [OFFSET_BITS-1:0]     pos_inc;

    assign o_byte_ready = !i_queue_full;
    assign accept       = i_byte_valid && o_byte_ready;

    assign blank    = (i_byte == rft_pkg::CH_SPACE) ||
                      ((i_byte >= rft_pkg::CH_TAB) && (i_byte <= rft_pkg::CH_CR));
    assign is_at    = (i_byte == rft_pkg::CH_AT);
    assign is_punct = (i_byte == rft_pkg::CH_SCOLON) || (i_byte == rft_pkg::CH_COLON);
    assign delim    = blank || is_at || is_punct;
    assign pos_inc  = r_pos + OFFSET_BITS'(1);

    always_comb begin
        n_mode  = r_mode;
        n_pos   = pos_inc;
        n_start = r_start;
        n_len   = r_len;
        n_flags = r_flags;
        do_idle = 1'b0;
        cand    = '0;
        cand_v  = '0;

        case (r_mode)
            rft_pkg::MODE_IDENT: begin
                if (delim) begin
                    cand[0]   = mk_res(rft_pkg::KIND_IDENT, 32'(r_start), r_len, r_flags);
                    cand_v[0] = 1'b1;
                    do_idle   = 1'b1;
                end else begin
                    n_len   = r_len + 32'd1;
                    n_flags = classify(r_flags, i_byte);
                end
            end
            rft_pkg::MODE_STR: begin
                if (is_at) n_mode = rft_pkg::MODE_STR_AT;
                else       n_len  = r_len + 32'd1;
            end
            rft_pkg::MODE_STR_AT: begin
                if (is_at) begin
                    n_len  = r_len + 32'd2;
                    n_mode = rft_pkg::MODE_STR;
                end else begin
                    cand[0]   = mk_res(rft_pkg::KIND_STRING, 32'(r_start), r_len,
                                       rft_pkg::FL_NONE);
                    cand_v[0] = 1'b1;
                    do_idle   = 1'b1;
                end
            end
            default: do_idle = 1'b1;
        endcase

        // Byte seen with no token open.
        if (do_idle) begin
            n_mode = rft_pkg::MODE_IDLE;
            if (is_at) begin
                n_mode  = rft_pkg::MODE_STR;
                n_start = pos_inc;
                n_len   = 32'd0;
            end else if (i_byte == rft_pkg::CH_SCOLON) begin
                cand[1]   = mk_res(rft_pkg::KIND_SCOLON, 32'(r_pos), 32'd1, rft_pkg::FL_NONE);
                cand_v[1] = 1'b1;
            end else if (i_byte == rft_pkg::CH_COLON) begin
                cand[1]   = mk_res(rft_pkg::KIND_COLON, 32'(r_pos), 32'd1, rft_pkg::FL_NONE);
                cand_v[1] = 1'b1;
            end else if (!blank) begin
                n_mode  = rft_pkg::MODE_IDENT;
                n_start = r_pos;
                n_len   = 32'd1;
                n_flags = classify(rft_pkg::FL_RESET, i_byte);
            end
        end

        // Final byte closes whatever is open, then the end or error token.
        if (i_eof) begin
            if (n_mode == rft_pkg::MODE_STR) begin
                cand[2]   = mk_res(rft_pkg::KIND_ERROR, 32'(n_start), n_len,
                                   rft_pkg::FL_NONE);
                cand_v[2] = 1'b1;
            end else begin
                if (n_mode == rft_pkg::MODE_IDENT) begin
                    cand[2]   = mk_res(rft_pkg::KIND_IDENT, 32'(n_start), n_len, n_flags);
                    cand_v[2] = 1'b1;
                end else if (n_mode == rft_pkg::MODE_STR_AT) begin
                    cand[2]   = mk_res(rft_pkg::KIND_STRING, 32'(n_start), n_len,
                                       rft_pkg::FL_NONE);
                    cand_v[2] = 1'b1;
                end
                cand[3]   = mk_res(rft_pkg::KIND_END, 32'(pos_inc), 32'd0, rft_pkg::FL_NONE);
                cand_v[3] = 1'b1;
            end
            n_mode  = rft_pkg::MODE_IDLE;
            n_pos   = '0;
            n_start = '0;
            n_len   = 32'd0;
            n_flags = rft_pkg::FL_RESET;
        end
    end

    // Pack the candidates into consecutive slots; at most three are ever live.
    always_comb begin
        o_bundle = '0;
        fill     = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && fill < 3'(rft_pkg::RES_MAX)) begin
                o_bundle.res[fill[1:0]] = cand[i];
                fill = fill + 3'd1;
            end
        end
        o_bundle.cnt = fill[1:0];
    end

    assign o_push = accept && (fill != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= rft_pkg::MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= 32'd0;
            r_flags <= rft_pkg::FL_RESET;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_flags <= n_flags;
        end
    end

    a_eof_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_eof |=> r_mode == rft_pkg::MODE_IDLE && r_pos == '0)
        else $error("scanner did not rearm after the final byte");

    a_eof_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_eof |-> o_push)
        else $error("final byte produced no closing token");

endmodule

>>> rtl/core/rft_queue.sv
module rft_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rft_pkg::t_bundle i_bundle,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output rft_pkg::t_bundle o_head
);

    rft_pkg::t_bundle                  r_mem [rft_pkg::QUEUE_DEPTH];
    logic [rft_pkg::QUEUE_AW-1:0]      r_wr, r_rd;
    logic [rft_pkg::QUEUE_AW:0]        r_cnt, n_cnt;

    assign o_full  = (r_cnt == (rft_pkg::QUEUE_AW+1)'(rft_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("bundle queue overflow or underflow");

endmodule

>>> rtl/core/rft_back.sv
module rft_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  rft_pkg::t_bundle            i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output rft_pkg::t_result            o_result,
    output logic                        o_last
);

    logic [1:0]        r_idx;
    logic              r_valid;
    rft_pkg::t_result  r_result;
    logic              r_last;
    logic              load;
    logic              head_last;

    assign load      = !i_empty && (!r_valid || i_ready);
    assign head_last = (r_idx == i_head.cnt - 2'd1);
    assign o_pop     = load && head_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= head_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_head.res[r_idx];
            r_last   <= head_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_last   = r_last;

    a_idx_inside_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd0 |-> !i_empty && r_idx < i_head.cnt)
        else $error("result index ran past its bundle");

endmodule

>>> bench/tb.sv
module tb;

    // Generous cycle budget; a correct run needs only a small part of it.
    localparam int unsigned LIMIT_CYCLES = 200000;

    // One expected token as it should leave the master side.
    typedef struct {
        rft_pkg::t_kind kind;
        logic [31:0]    start;
        logic [31:0]    len;
        logic           num;
        logic           id;
        logic           sym;
        logic           last;
    } t_tok;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [7:0]                    i_s_tdata  = 8'h00;
    logic                          i_s_tlast  = 1'b0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [rft_pkg::TDATA_W-1:0]   o_m_tdata;
    logic [2:0]                    o_m_tuser;
    logic                          o_m_tlast;

    rcs_file_tokenizer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Tokens still owed by the block, oldest first, and the tokens that the
    // byte being predicted right now gives rise to.
    t_tok        token_fifo[$];
    t_tok        step_toks[$];
    logic [7:0]  file_bytes[$];

    int unsigned fail_cnt  = 0;
    int unsigned byte_cnt  = 0;
    int unsigned cycle_cnt = 0;

    // Both sides insert random gaps while these are set.
    bit src_gaps_on    = 1'b1;
    bit sink_stalls_on = 1'b1;

    // Scanner state of the tokenizer model kept by the bench.
    rft_pkg::t_mode  scan_q;
    logic [31:0]     pos_q;
    logic [31:0]     open_start_q;
    logic [31:0]     open_len_q;
    rft_pkg::t_flags flags_q;

    function automatic bit is_blank(input logic [7:0] c);
        return c == rft_pkg::CH_SPACE || (c >= rft_pkg::CH_TAB && c <= rft_pkg::CH_CR);
    endfunction

    function automatic bit is_delim(input logic [7:0] c);
        return is_blank(c) || c == rft_pkg::CH_AT || c == rft_pkg::CH_SCOLON ||
               c == rft_pkg::CH_COLON;
    endfunction

    function void clear_scan();
        scan_q       = rft_pkg::MODE_IDLE;
        pos_q        = '0;
        open_start_q = '0;
        open_len_q   = '0;
        flags_q      = rft_pkg::FL_RESET;
    endfunction

    // Update the identifier class flags with one more identifier byte.
    function void classify_byte(input logic [7:0] c);
        logic dig;
        logic pr;
        logic spec;
        dig  = c >= rft_pkg::CH_ZERO && c <= rft_pkg::CH_NINE;
        pr   = c >= rft_pkg::CH_SPACE && c <= rft_pkg::CH_TILDE;
        spec = c == rft_pkg::CH_DOLLAR || c == rft_pkg::CH_COMMA || c == rft_pkg::CH_COLON ||
               c == rft_pkg::CH_SCOLON || c == rft_pkg::CH_AT;
        if (!dig && c != rft_pkg::CH_DOT) begin
            flags_q.num   = 1'b0;
            flags_q.id_ch = 1'b1;
        end
        if (spec || !pr)
            flags_q.id = 1'b0;
        if (spec || c == rft_pkg::CH_DOT || !pr)
            flags_q.sym = 1'b0;
        if (!dig)
            flags_q.sym_ch = 1'b1;
    endfunction

    function void add_token(input rft_pkg::t_kind k, input logic [31:0] st,
                            input logic [31:0] ln, input rft_pkg::t_flags f);
        t_tok t;
        t.kind  = k;
        t.start = st;
        t.len   = ln;
        t.num   = f.num;
        t.id    = f.id && f.id_ch;
        t.sym   = f.sym && f.sym_ch;
        t.last  = 1'b0;
        step_toks.push_back(t);
    endfunction

    // A byte that arrives while no token is open.
    function void start_token(input logic [7:0] c);
        if (is_blank(c))
            return;
        if (c == rft_pkg::CH_AT) begin
            scan_q       = rft_pkg::MODE_STR;
            open_start_q = pos_q + 32'd1;
            open_len_q   = '0;
        end else if (c == rft_pkg::CH_SCOLON) begin
            add_token(rft_pkg::KIND_SCOLON, pos_q, 32'd1, rft_pkg::FL_NONE);
        end else if (c == rft_pkg::CH_COLON) begin
            add_token(rft_pkg::KIND_COLON, pos_q, 32'd1, rft_pkg::FL_NONE);
        end else begin
            scan_q       = rft_pkg::MODE_IDENT;
            open_start_q = pos_q;
            open_len_q   = 32'd1;
            flags_q      = rft_pkg::FL_RESET;
            classify_byte(c);
        end
    endfunction

    // Work out every token caused by one accepted byte and queue them up.
    function void tokenize_byte(input logic [7:0] c, input logic eof);
        t_tok t;
        step_toks.delete();
        case (scan_q)
            rft_pkg::MODE_IDENT: begin
                if (is_delim(c)) begin
                    add_token(rft_pkg::KIND_IDENT, open_start_q, open_len_q, flags_q);
                    scan_q = rft_pkg::MODE_IDLE;
                    start_token(c);
                end else begin
                    open_len_q = open_len_q + 32'd1;
                    classify_byte(c);
                end
            end
            rft_pkg::MODE_STR: begin
                if (c == rft_pkg::CH_AT)
                    scan_q = rft_pkg::MODE_STR_AT;
                else
                    open_len_q = open_len_q + 32'd1;
            end
            rft_pkg::MODE_STR_AT: begin
                // A second at-sign is an escape; anything else closes the string.
                if (c == rft_pkg::CH_AT) begin
                    open_len_q = open_len_q + 32'd2;
                    scan_q     = rft_pkg::MODE_STR;
                end else begin
                    add_token(rft_pkg::KIND_STRING, open_start_q, open_len_q,
                              rft_pkg::FL_NONE);
                    scan_q = rft_pkg::MODE_IDLE;
                    start_token(c);
                end
            end
            default: begin
                scan_q = rft_pkg::MODE_IDLE;
                start_token(c);
            end
        endcase
        pos_q = pos_q + 32'd1;

        // The final byte closes what is open, reports the end or the error
        // of an unterminated string, and the scanner starts a fresh file.
        if (eof) begin
            if (scan_q == rft_pkg::MODE_STR) begin
                add_token(rft_pkg::KIND_ERROR, open_start_q, open_len_q, rft_pkg::FL_NONE);
            end else begin
                if (scan_q == rft_pkg::MODE_IDENT)
                    add_token(rft_pkg::KIND_IDENT, open_start_q, open_len_q, flags_q);
                else if (scan_q == rft_pkg::MODE_STR_AT)
                    add_token(rft_pkg::KIND_STRING, open_start_q, open_len_q,
                              rft_pkg::FL_NONE);
                add_token(rft_pkg::KIND_END, pos_q, 32'd0, rft_pkg::FL_NONE);
            end
            clear_scan();
        end

        foreach (step_toks[i]) begin
            t      = step_toks[i];
            t.last = (i == step_toks.size() - 1);
            token_fifo.push_back(t);
        end
    endfunction

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // Sender: each cycle before the beat is left idle at random while gaps
    // are on, then the byte is held until the beat is taken and its tokens
    // are predicted. The valid stays high into the next call unless that
    // call opens a gap, so it is never lowered and raised in one step.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        while (src_gaps_on && $urandom_range(99) < 28) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eof;
        do @(posedge i_clk); while (!o_s_tready);
        tokenize_byte(b, eof);
        byte_cnt++;
    endtask

    task automatic send_text(input string s, input bit eof_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eof_at_end && i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_blank();
        logic [7:0] c;
        c = 8'($urandom_range(8, 13));
        if (c == 8'd8)
            c = rft_pkg::CH_SPACE;
        return c;
    endfunction

    // A byte that may stand inside an identifier, biased toward the
    // characters that decide the num, id and sym flags.
    function automatic logic [7:0] pick_ident_byte();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0, 1: c = 8'($urandom_range(rft_pkg::CH_ZERO, rft_pkg::CH_NINE));
            2: c = rft_pkg::CH_DOT;
            3: c = 8'($urandom_range(8'h41, 8'h7A));
            4: c = $urandom_range(0, 1) ? rft_pkg::CH_DOLLAR : rft_pkg::CH_COMMA;
            default: begin
                do c = 8'($urandom_range(0, 255)); while (is_delim(c));
            end
        endcase
        return c;
    endfunction

    function automatic void add_string_body();
        logic [7:0] c;
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) begin
                file_bytes.push_back(rft_pkg::CH_AT);
                file_bytes.push_back(rft_pkg::CH_AT);
            end else begin
                do c = 8'($urandom_range(0, 255)); while (c == rft_pkg::CH_AT);
                file_bytes.push_back(c);
            end
        end
    endfunction

    // Build one well-formed file of random tokens; now and then it ends in
    // the middle of a string to provoke the error token.
    function automatic void build_file();
        file_bytes.delete();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(1, 8))
                        file_bytes.push_back(pick_ident_byte());
                end
                4, 5, 6: begin
                    file_bytes.push_back(rft_pkg::CH_AT);
                    add_string_body();
                    file_bytes.push_back(rft_pkg::CH_AT);
                end
                7: file_bytes.push_back(rft_pkg::CH_SCOLON);
                8: file_bytes.push_back(rft_pkg::CH_COLON);
                default: begin
                    repeat ($urandom_range(1, 3))
                        file_bytes.push_back(pick_blank());
                end
            endcase
            if ($urandom_range(0, 2) != 0) begin
                repeat ($urandom_range(1, 2))
                    file_bytes.push_back(pick_blank());
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            file_bytes.push_back(rft_pkg::CH_AT);
            add_string_body();
        end
    endfunction

    task automatic send_file();
        build_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // Hand-picked bytes: string with an escaped at-sign, both one-byte
    // tokens, identifiers with non-printable and extreme bytes, every kind
    // of whitespace but the space, and each way a file can end.
    task automatic test_directed();
        send_text("@a@@b@;", 1'b0);
        send_text(":", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(rft_pkg::CH_TAB, 1'b0);
        send_text("1.2\n", 1'b0);
        send_text("a.b\r", 1'b0);
        // An at-sign on the final byte leaves an unterminated string.
        send_text("@", 1'b1);
        // A final at-sign closes the string before the end token.
        send_text("@x@", 1'b1);
        // A one-byte token that starts at the final byte.
        send_byte(8'h0C, 1'b0);
        send_text(";", 1'b1);
        send_text("z", 1'b1);
        // Whitespace alone on the final byte gives just the end token.
        send_byte(8'h0B, 1'b1);
    endtask

    // A stretch with no gaps on either side, at full rate.
    task automatic test_full_rate();
        int unsigned first;
        first          = byte_cnt;
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        while (byte_cnt - first < 50)
            send_file();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // Mostly random files, with bursts of raw noise that may end a file
    // anywhere.
    task automatic test_random_files();
        int unsigned first;
        first = byte_cnt;
        while (byte_cnt - first < 220) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(4, 12))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end else begin
                send_file();
            end
        end
    endtask

    // Receiver: ready drops at random while stalls are enabled.
    always @(posedge i_clk) begin
        if (sink_stalls_on)
            i_m_tready <= ($urandom_range(99) >= 28);
        else
            i_m_tready <= 1'b1;
    end

    // Every token beat is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_tok want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (token_fifo.size() == 0) begin
                $error("token beat with nothing expected: kind %0d start %0d",
                       o_m_tuser, o_m_tdata[31:0]);
                fail_cnt++;
            end else begin
                want = token_fifo.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_m_tuser));
                check_field("start_offset", want.start, o_m_tdata[31:0]);
                check_field("token_length", want.len, o_m_tdata[63:32]);
                check_field("num_valid", 32'(want.num), 32'(o_m_tdata[64]));
                check_field("id_valid", 32'(want.id), 32'(o_m_tdata[65]));
                check_field("sym_valid", 32'(want.sym), 32'(o_m_tdata[66]));
                check_field("tdata_pad", 32'd0, 32'(o_m_tdata[71:67]));
                check_field("last_of_run", 32'(want.last), 32'(o_m_tlast));
            end
        end
    end

    // Watchdog on the cycle count.
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        clear_scan();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_rate();
        test_random_files();
        i_s_tvalid <= 1'b0;

        // Drain every owed token, then let the pipeline settle so that a
        // stray extra beat would still be seen.
        while (token_fifo.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
